[sv/assert_macros.svh]
// Assertion macros for the two-state Kalman filter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KFT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define KFT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KFT_ASSERT(lbl, clk, rstn, prop, msg)
`define KFT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/kft_pkg.sv]
// Package for the two-state Kalman filter: sequencer states, operand codes,
// microcode row format and the microcode table. No dependencies.
`default_nettype none
package kft_pkg;

    localparam int KFT_STATES    = 2;
    localparam int KFT_FRAC_BITS = 16;

    localparam int ROW_W      = 6;
    localparam logic [ROW_W-1:0] PRED_LAST = 6'd19;
    localparam logic [ROW_W-1:0] UPD_FIRST = 6'd20;
    localparam logic [ROW_W-1:0] UPD_LAST  = 6'd47;

    localparam logic [2:0] REG_COUPLING = 3'd0;
    localparam logic [2:0] REG_Q_PP     = 3'd1;
    localparam logic [2:0] REG_Q_PV     = 3'd2;
    localparam logic [2:0] REG_Q_VV     = 3'd3;
    localparam logic [2:0] REG_B_POS    = 3'd4;
    localparam logic [2:0] REG_B_VEL    = 3'd5;
    localparam logic [2:0] REG_R        = 3'd6;
    localparam logic [2:0] REG_GATE     = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_GATE_YY,
        ST_GATE_GS,
        ST_GATE_CMP,
        ST_DIV0,
        ST_DIV1,
        ST_UPD,
        ST_DONE
    } seq_state_t;

    typedef enum logic [4:0] {
        OP_ZERO, OP_X0, OP_X1, OP_P00, OP_P01, OP_P11, OP_U, OP_Z,
        OP_F01, OP_Q00, OP_Q01, OP_Q11, OP_B0, OP_B1, OP_R, OP_FP00,
        OP_FP01, OP_Y, OP_S, OP_G0, OP_G1, OP_AP00, OP_AP01, OP_AP10,
        OP_AP11, OP_RG0, OP_RG1, OP_NP01, OP_NP10
    } operand_t;

    typedef enum logic [1:0] {
        K_ADD,   // acc += a
        K_SUB,   // acc -= a
        K_MAC,   // acc += round(a*b)
        K_MSUB   // acc -= round(a*b)
    } op_kind_t;

    typedef struct packed {
        logic     first;
        logic     last;
        logic     halve;
        op_kind_t kind;
        operand_t a;
        operand_t b;
        operand_t dst;
    } urow_t;

    function automatic urow_t mk(logic f, logic l, op_kind_t k, operand_t a,
                                 operand_t b, operand_t d);
        urow_t r;
        r.first = f;
        r.last  = l;
        r.halve = 1'b0;
        r.kind  = k;
        r.a     = a;
        r.b     = b;
        r.dst   = d;
        return r;
    endfunction

    function automatic urow_t ucode(logic [ROW_W-1:0] idx);
        urow_t r;
        r = mk(1'b0, 1'b0, K_ADD, OP_ZERO, OP_ZERO, OP_ZERO);
        case (idx)
            // predict state
            6'd0:  r = mk(1'b1, 1'b0, K_ADD, OP_X0,   OP_ZERO, OP_ZERO);
            6'd1:  r = mk(1'b0, 1'b0, K_MAC, OP_B0,   OP_U,    OP_ZERO);
            6'd2:  r = mk(1'b0, 1'b1, K_MAC, OP_F01,  OP_X1,   OP_X0);
            6'd3:  r = mk(1'b1, 1'b0, K_ADD, OP_X1,   OP_ZERO, OP_ZERO);
            6'd4:  r = mk(1'b0, 1'b1, K_MAC, OP_B1,   OP_U,    OP_X1);
            // F*P
            6'd5:  r = mk(1'b1, 1'b0, K_ADD, OP_P00,  OP_ZERO, OP_ZERO);
            6'd6:  r = mk(1'b0, 1'b1, K_MAC, OP_F01,  OP_P01,  OP_FP00);
            6'd7:  r = mk(1'b1, 1'b0, K_ADD, OP_P01,  OP_ZERO, OP_ZERO);
            6'd8:  r = mk(1'b0, 1'b1, K_MAC, OP_F01,  OP_P11,  OP_FP01);
            // F*P*F' + Q
            6'd9:  r = mk(1'b1, 1'b0, K_ADD, OP_Q00,  OP_ZERO, OP_ZERO);
            6'd10: r = mk(1'b0, 1'b0, K_ADD, OP_FP00, OP_ZERO, OP_ZERO);
            6'd11: r = mk(1'b0, 1'b1, K_MAC, OP_FP01, OP_F01,  OP_P00);
            6'd12: r = mk(1'b1, 1'b0, K_ADD, OP_Q01,  OP_ZERO, OP_ZERO);
            6'd13: r = mk(1'b0, 1'b1, K_ADD, OP_FP01, OP_ZERO, OP_P01);
            6'd14: r = mk(1'b1, 1'b0, K_ADD, OP_Q11,  OP_ZERO, OP_ZERO);
            6'd15: r = mk(1'b0, 1'b1, K_ADD, OP_P11,  OP_ZERO, OP_P11);
            // innovation and its variance
            6'd16: r = mk(1'b1, 1'b0, K_ADD, OP_Z,    OP_ZERO, OP_ZERO);
            6'd17: r = mk(1'b0, 1'b1, K_SUB, OP_X0,   OP_ZERO, OP_Y);
            6'd18: r = mk(1'b1, 1'b0, K_ADD, OP_R,    OP_ZERO, OP_ZERO);
            6'd19: r = mk(1'b0, 1'b1, K_ADD, OP_P00,  OP_ZERO, OP_S);
            // state update
            6'd20: r = mk(1'b1, 1'b0, K_ADD, OP_X0,   OP_ZERO, OP_ZERO);
            6'd21: r = mk(1'b0, 1'b1, K_MAC, OP_G0,   OP_Y,    OP_X0);
            6'd22: r = mk(1'b1, 1'b0, K_ADD, OP_X1,   OP_ZERO, OP_ZERO);
            6'd23: r = mk(1'b0, 1'b1, K_MAC, OP_G1,   OP_Y,    OP_X1);
            // (I-KH)P
            6'd24: r = mk(1'b1, 1'b0, K_ADD, OP_P00,  OP_ZERO, OP_ZERO);
            6'd25: r = mk(1'b0, 1'b1, K_MSUB, OP_G0,  OP_P00,  OP_AP00);
            6'd26: r = mk(1'b1, 1'b0, K_ADD, OP_P01,  OP_ZERO, OP_ZERO);
            6'd27: r = mk(1'b0, 1'b1, K_MSUB, OP_G0,  OP_P01,  OP_AP01);
            6'd28: r = mk(1'b1, 1'b0, K_ADD, OP_P01,  OP_ZERO, OP_ZERO);
            6'd29: r = mk(1'b0, 1'b1, K_MSUB, OP_G1,  OP_P00,  OP_AP10);
            6'd30: r = mk(1'b1, 1'b0, K_ADD, OP_P11,  OP_ZERO, OP_ZERO);
            6'd31: r = mk(1'b0, 1'b1, K_MSUB, OP_G1,  OP_P01,  OP_AP11);
            // R*K
            6'd32: r = mk(1'b1, 1'b1, K_MAC, OP_R,    OP_G0,   OP_RG0);
            6'd33: r = mk(1'b1, 1'b1, K_MAC, OP_R,    OP_G1,   OP_RG1);
            // Joseph form
            6'd34: r = mk(1'b1, 1'b0, K_ADD, OP_AP00, OP_ZERO, OP_ZERO);
            6'd35: r = mk(1'b0, 1'b0, K_MSUB, OP_G0,  OP_AP00, OP_ZERO);
            6'd36: r = mk(1'b0, 1'b1, K_MAC, OP_RG0,  OP_G0,   OP_P00);
            6'd37: r = mk(1'b1, 1'b0, K_ADD, OP_AP01, OP_ZERO, OP_ZERO);
            6'd38: r = mk(1'b0, 1'b0, K_MSUB, OP_G1,  OP_AP00, OP_ZERO);
            6'd39: r = mk(1'b0, 1'b1, K_MAC, OP_RG0,  OP_G1,   OP_NP01);
            6'd40: r = mk(1'b1, 1'b0, K_ADD, OP_AP10, OP_ZERO, OP_ZERO);
            6'd41: r = mk(1'b0, 1'b0, K_MSUB, OP_G0,  OP_AP10, OP_ZERO);
            6'd42: r = mk(1'b0, 1'b1, K_MAC, OP_RG1,  OP_G0,   OP_NP10);
            6'd43: r = mk(1'b1, 1'b0, K_ADD, OP_AP11, OP_ZERO, OP_ZERO);
            6'd44: r = mk(1'b0, 1'b0, K_MSUB, OP_G1,  OP_AP10, OP_ZERO);
            6'd45: r = mk(1'b0, 1'b1, K_MAC, OP_RG1,  OP_G1,   OP_P11);
            // symmetric cross term: floor of the mean
            6'd46: r = mk(1'b1, 1'b0, K_ADD, OP_NP01, OP_ZERO, OP_ZERO);
            6'd47:
            begin
                r = mk(1'b0, 1'b1, K_ADD, OP_NP10, OP_ZERO, OP_P01);
                r.halve = 1'b1;
            end
            default: r = mk(1'b0, 1'b0, K_ADD, OP_ZERO, OP_ZERO, OP_ZERO);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(logic signed [63:0] v);
        logic hi_ok;
        hi_ok = (v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}});
        if (hi_ok)
            return v[31:0];
        else if (v[63])
            return 32'h8000_0000;
        else
            return 32'h7FFF_FFFF;
    endfunction

endpackage
`default_nettype wire

[sv/kft_div.sv]
// Iterative restoring divider for the Kalman gain: num * 2^FRAC_BITS / den,
// truncated toward zero and saturated to 32 bits. Uses kft_pkg.
`default_nettype none
module kft_div
    import kft_pkg::*;
#(
    parameter int FRAC_BITS = KFT_FRAC_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [31:0]      quot
);
    localparam int W  = 32 + FRAC_BITS;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  q_reg, q_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [31:0]   mag;
    logic [32:0]   trial;
    logic          fits;

    assign mag   = num[31] ? (~num + 32'd1) : num;
    assign trial = {rem_reg, dvd_reg[W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            dvd_next  = {mag, {FRAC_BITS{1'b0}}};
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[31];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            q_next   = {q_reg[W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // saturate the magnitude quotient, then apply the sign
    always_comb
    begin
        if (neg_reg)
        begin
            if ((|q_reg[W-1:32]) || (q_reg[31] && (|q_reg[30:0])))
                quot = 32'h8000_0000;
            else
                quot = ~q_reg[31:0] + 32'd1;
        end
        else
        begin
            if (|q_reg[W-1:31])
                quot = 32'h7FFF_FFFF;
            else
                quot = q_reg[31:0];
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

[sv/kalman_filter_two_state.sv]
// Two-state Kalman filter top level: APB register file, microcoded sequencer
// around one shared 32x32 multiplier and accumulator. Uses kft_pkg, kft_div.
//
//  channel   signals                                          direction  moves
//  sample    sample_valid/sample_stall, control_value,        in         one step input
//            measurement
//  result    result_valid/result_stall, 8 fields              out        one step result
//  config    psel/penable/pwrite/paddr/pwdata                 in         register writes
//
// A rejected update skips the gain divisions and goes from the gate check
// straight to the result. Arithmetic is Q16.16 at the default FRAC_BITS.
// Every microcode row has a multiply phase and an accumulate phase on the
// shared multiplier, and each of the two gain divisions runs in the bit-serial divider.
// sample_stall is high from accept until the result is in the output register.
// Reset loads zero state and unit covariance. A stalled result holds while
// the next sample is taken and worked on.
`default_nettype none
module kalman_filter_two_state
    import kft_pkg::*;
#(
    parameter int STATES    = KFT_STATES,
    parameter int FRAC_BITS = KFT_FRAC_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire logic [31:0] control_value,
    input  wire logic [31:0] measurement,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      position_estimate,
    output logic [31:0]      velocity_estimate,
    output logic [31:0]      innovation,
    output logic [31:0]      innovation_variance,
    output logic             update_accepted,
    output logic [31:0]      var_position,
    output logic [31:0]      cov_cross,
    output logic [31:0]      var_velocity
);
    localparam logic        TWO    = (STATES >= 2);
    localparam logic [31:0] ONE_Q  = 32'(64'd1 << FRAC_BITS);
    localparam logic [63:0] HALF_Q = 64'd1 << (FRAC_BITS - 1);

    // ---------------- configuration registers ----------------
    logic [31:0] coupling_reg, q_pv_reg, b_pos_reg, b_vel_reg;
    logic [30:0] q_pp_reg, q_vv_reg, r_reg, gate_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg <= ONE_Q;
            q_pp_reg     <= '0;
            q_pv_reg     <= '0;
            q_vv_reg     <= '0;
            b_pos_reg    <= '0;
            b_vel_reg    <= '0;
            r_reg        <= ONE_Q[30:0];
            gate_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_COUPLING: coupling_reg <= pwdata;
                REG_Q_PP:     q_pp_reg     <= pwdata[30:0];
                REG_Q_PV:     q_pv_reg     <= pwdata;
                REG_Q_VV:     q_vv_reg     <= pwdata[30:0];
                REG_B_POS:    b_pos_reg    <= pwdata;
                REG_B_VEL:    b_vel_reg    <= pwdata;
                REG_R:        r_reg        <= pwdata[30:0];
                REG_GATE:     gate_reg     <= pwdata[30:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_COUPLING: prdata = coupling_reg;
            REG_Q_PP:     prdata = {1'b0, q_pp_reg};
            REG_Q_PV:     prdata = q_pv_reg;
            REG_Q_VV:     prdata = {1'b0, q_vv_reg};
            REG_B_POS:    prdata = b_pos_reg;
            REG_B_VEL:    prdata = b_vel_reg;
            REG_R:        prdata = {1'b0, r_reg};
            REG_GATE:     prdata = {1'b0, gate_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    seq_state_t       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             phase_reg, phase_next;
    logic             ok_reg;
    urow_t            row;

    logic accept, step, wr_en, div_start, div_done, load_out, out_free, ok_now;
    logic [31:0] div_quot;

    // state and scratch
    logic [31:0] x0_reg, x1_reg, p00_reg, p01_reg, p11_reg;
    logic [31:0] u_reg, z_reg, y_reg, s_reg, fp00_reg, fp01_reg, g0_reg, g1_reg;
    logic [31:0] ap00_reg, ap01_reg, ap10_reg, ap11_reg, rg0_reg, rg1_reg;
    logic [31:0] np01_reg, np10_reg;

    // shared multiply/accumulate
    logic signed [63:0] prod_reg, yy_reg, acc_reg;
    logic signed [63:0] qm, term, acc_sum;
    logic [31:0] opa, opb, mul_a, mul_b, wr_data;

    assign row      = ucode(row_reg);
    assign out_free = !result_valid || !result_stall;
    assign ok_now   = ($signed(s_reg) > 32'sd0)
                      && !((gate_reg != '0) && (yy_reg > prod_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (sample_valid) state_next = ST_PRED;
            ST_PRED:     if (phase_reg && row_reg == PRED_LAST) state_next = ST_GATE_YY;
            ST_GATE_YY:  state_next = ST_GATE_GS;
            ST_GATE_GS:  state_next = ST_GATE_CMP;
            ST_GATE_CMP: state_next = ok_now ? ST_DIV0 : ST_DONE;
            ST_DIV0:     if (div_done) state_next = ST_DIV1;
            ST_DIV1:     if (div_done) state_next = ST_UPD;
            ST_UPD:      if (phase_reg && row_reg == UPD_LAST) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_stall = (state_reg != ST_IDLE);
        accept       = (state_reg == ST_IDLE) && sample_valid;
        step         = phase_reg && (state_reg == ST_PRED || state_reg == ST_UPD);
        wr_en        = step && row.last;
        div_start    = ((state_reg == ST_GATE_CMP) && ok_now)
                       || ((state_reg == ST_DIV0) && div_done);
        load_out     = (state_reg == ST_DONE) && out_free;
        row_next     = row_reg;
        phase_next   = 1'b0;
        if (accept)
            row_next = '0;
        else if (state_reg == ST_GATE_CMP)
            row_next = UPD_FIRST;
        else if (step)
            row_next = row_reg + ROW_W'(1);
        if (state_reg == ST_PRED || state_reg == ST_UPD)
            phase_next = !phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            phase_reg <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
            if (state_reg == ST_GATE_CMP)
                ok_reg <= ok_now;
        end
    end

    // operand select; velocity terms read as zero in the one-state model
    function automatic logic [31:0] pick(operand_t sel, logic [31:0] x0, logic [31:0] x1,
                                         logic [31:0] p00, logic [31:0] p01,
                                         logic [31:0] p11, logic [31:0] f01);
        logic [31:0] v;
        v = '0;
        case (sel)
            OP_X0:   v = x0;
            OP_X1:   v = x1;
            OP_P00:  v = p00;
            OP_P01:  v = p01;
            OP_P11:  v = p11;
            OP_F01:  v = f01;
            default: v = '0;
        endcase
        return v;
    endfunction

    logic [31:0] x1_m, p01_m, p11_m, f01_m;
    assign x1_m  = TWO ? x1_reg  : '0;
    assign p01_m = TWO ? p01_reg : '0;
    assign p11_m = TWO ? p11_reg : '0;
    assign f01_m = TWO ? coupling_reg : '0;

    function automatic logic [31:0] pick_tmp(operand_t sel, logic [31:0] st,
        logic [31:0] u, logic [31:0] z, logic [31:0] q00, logic [31:0] q01,
        logic [31:0] q11, logic [31:0] b0, logic [31:0] b1, logic [31:0] r,
        logic [31:0] fp00, logic [31:0] fp01, logic [31:0] y, logic [31:0] s,
        logic [31:0] g0, logic [31:0] g1, logic [31:0] ap00, logic [31:0] ap01,
        logic [31:0] ap10, logic [31:0] ap11, logic [31:0] rg0, logic [31:0] rg1,
        logic [31:0] np01, logic [31:0] np10);
        logic [31:0] v;
        v = st;
        case (sel)
            OP_U:    v = u;
            OP_Z:    v = z;
            OP_Q00:  v = q00;
            OP_Q01:  v = q01;
            OP_Q11:  v = q11;
            OP_B0:   v = b0;
            OP_B1:   v = b1;
            OP_R:    v = r;
            OP_FP00: v = fp00;
            OP_FP01: v = fp01;
            OP_Y:    v = y;
            OP_S:    v = s;
            OP_G0:   v = g0;
            OP_G1:   v = g1;
            OP_AP00: v = ap00;
            OP_AP01: v = ap01;
            OP_AP10: v = ap10;
            OP_AP11: v = ap11;
            OP_RG0:  v = rg0;
            OP_RG1:  v = rg1;
            OP_NP01: v = np01;
            OP_NP10: v = np10;
            default: v = st;
        endcase
        return v;
    endfunction

    always_comb
    begin
        opa = pick_tmp(row.a, pick(row.a, x0_reg, x1_m, p00_reg, p01_m, p11_m, f01_m),
                       u_reg, z_reg, {1'b0, q_pp_reg}, q_pv_reg, {1'b0, q_vv_reg},
                       b_pos_reg, b_vel_reg, {1'b0, r_reg}, fp00_reg, fp01_reg,
                       y_reg, s_reg, g0_reg, g1_reg, ap00_reg, ap01_reg, ap10_reg,
                       ap11_reg, rg0_reg, rg1_reg, np01_reg, np10_reg);
        opb = pick_tmp(row.b, pick(row.b, x0_reg, x1_m, p00_reg, p01_m, p11_m, f01_m),
                       u_reg, z_reg, {1'b0, q_pp_reg}, q_pv_reg, {1'b0, q_vv_reg},
                       b_pos_reg, b_vel_reg, {1'b0, r_reg}, fp00_reg, fp01_reg,
                       y_reg, s_reg, g0_reg, g1_reg, ap00_reg, ap01_reg, ap10_reg,
                       ap11_reg, rg0_reg, rg1_reg, np01_reg, np10_reg);
        case (state_reg)
            ST_GATE_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            ST_GATE_GS:
            begin
                mul_a = {1'b0, gate_reg};
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = opa;
                mul_b = opb;
            end
        endcase
    end

    // product rounded to nearest, ties up
    assign qm = (prod_reg + $signed(HALF_Q)) >>> FRAC_BITS;

    always_comb
    begin
        case (row.kind)
            K_ADD:   term = 64'($signed(opa));
            K_SUB:   term = -64'($signed(opa));
            K_MAC:   term = qm;
            K_MSUB:  term = -qm;
            default: term = '0;
        endcase
        acc_sum = (row.first ? 64'sd0 : acc_reg) + term;
        wr_data = row.halve ? 32'(acc_sum >>> 1) : sat32(acc_sum);
    end

    always_ff @(posedge clk)
    begin
        if (!phase_reg)
            prod_reg <= $signed(mul_a) * $signed(mul_b);
        if (state_reg == ST_GATE_GS)
            yy_reg <= prod_reg;
        if (step)
            acc_reg <= acc_sum;
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_reg  <= '0;
            x1_reg  <= '0;
            p00_reg <= ONE_Q;
            p01_reg <= '0;
            p11_reg <= ONE_Q;
        end
        else if (wr_en)
        begin
            case (row.dst)
                OP_X0:   x0_reg  <= wr_data;
                OP_X1:   x1_reg  <= wr_data;
                OP_P00:  p00_reg <= wr_data;
                OP_P01:  p01_reg <= wr_data;
                OP_P11:  p11_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // scratch registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_reg <= control_value;
            z_reg <= measurement;
        end
        if (div_done)
        begin
            if (state_reg == ST_DIV0)
                g0_reg <= div_quot;
            else
                g1_reg <= div_quot;
        end
        if (wr_en)
        begin
            case (row.dst)
                OP_FP00: fp00_reg <= wr_data;
                OP_FP01: fp01_reg <= wr_data;
                OP_Y:    y_reg    <= wr_data;
                OP_S:    s_reg    <= wr_data;
                OP_AP00: ap00_reg <= wr_data;
                OP_AP01: ap01_reg <= wr_data;
                OP_AP10: ap10_reg <= wr_data;
                OP_AP11: ap11_reg <= wr_data;
                OP_RG0:  rg0_reg  <= wr_data;
                OP_RG1:  rg1_reg  <= wr_data;
                OP_NP01: np01_reg <= wr_data;
                OP_NP10: np10_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // gains: P00/s then P01/s
    kft_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ((state_reg == ST_GATE_CMP) ? p00_reg : p01_m),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- result register ----------------
    logic result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load_out)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            position_estimate   <= x0_reg;
            velocity_estimate   <= x1_m;
            innovation          <= y_reg;
            innovation_variance <= s_reg;
            update_accepted     <= ok_reg;
            var_position        <= p00_reg;
            cov_cross           <= p01_m;
            var_velocity        <= p11_m;
        end
    end

    assign result_valid = result_valid_reg;

    // ---------------- checks ----------------
`include "assert_macros.svh"
    `KFT_ASSERT(a_accept_pos_var, clk, rst_n, (result_valid && update_accepted) |-> ($signed(innovation_variance) > 32'sd0), "accepted update with non-positive variance")
    `KFT_ASSERT(a_div_in_div_state, clk, rst_n, div_done |-> (state_reg == ST_DIV0 || state_reg == ST_DIV1), "divider finished outside a gain state")
    `KFT_ASSERT(a_pred_row_range, clk, rst_n, (state_reg == ST_PRED) |-> (row_reg <= PRED_LAST), "predict row out of range")

endmodule
`default_nettype wire
